// File: rtl/core/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the strided, padded 2D convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

  localparam int MAX_DIM_DEF      = 32;
  localparam int MAX_KERNEL_DEF   = 8;
  localparam int MAX_CHANNELS_DEF = 4;

  localparam int ACC_W  = 48;
  localparam int DIM_W  = 9;
  localparam int QDEPTH = 2;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_WEIGHT = 2'd1;
  localparam logic [1:0] FUNC_BIAS   = 2'd2;
  localparam logic [1:0] FUNC_CONV   = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_WEIGHT,
    OP_BIAS,
    OP_CONV
  } c2d_kind_e;

  typedef struct packed {
    c2d_kind_e    kind;
    logic [1:0]   chan;
    logic [4:0]   row;
    logic [4:0]   col;
    logic [15:0]  value;
    logic [2:0]   used;
  } c2d_op_t;

  typedef struct packed {
    logic [DIM_W-1:0] ir;
    logic [DIM_W-1:0] ic;
    logic [3:0]       kr;
    logic [3:0]       kc;
    logic [3:0]       sr;
    logic [3:0]       sc;
    logic [2:0]       pr;
    logic [2:0]       pc;
  } c2d_geom_t;

endpackage

`default_nettype wire

// File: rtl/core/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/c2d_front.sv
// ----------------------------------------------------------------------------
// c2d_front
// Accepts input items, drops loads outside the stores, and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_front import c2d_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  output logic             op_valid_o,
  output c2d_op_t          op_o,
  input  wire logic        op_ready_i
);

  localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  c2d_op_t          q_mem_q [QDEPTH];
  logic [QPW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   count_q, count_d;
  c2d_op_t          op_in;
  logic             keep, push, pop;

  always_comb begin
    op_in.chan  = s_axis_tdata[1:0];
    op_in.row   = s_axis_tdata[6:2];
    op_in.col   = s_axis_tdata[11:7];
    op_in.value = s_axis_tdata[27:12];
    op_in.used  = s_axis_tdata[30:28];
    op_in.kind  = OP_CONV;
    keep        = 1'b1;
    case (s_axis_tuser)
      FUNC_SAMPLE: begin
        op_in.kind = OP_SAMPLE;
        keep = (int'(op_in.chan) < MAX_CHANNELS) && (int'(op_in.row) < MAX_DIM) &&
               (int'(op_in.col) < MAX_DIM);
      end
      FUNC_WEIGHT: begin
        op_in.kind = OP_WEIGHT;
        keep = (int'(op_in.chan) < MAX_CHANNELS) && (int'(op_in.row) < MAX_KERNEL) &&
               (int'(op_in.col) < MAX_KERNEL);
      end
      FUNC_BIAS: begin
        op_in.kind = OP_BIAS;
      end
      default: begin
        op_in.kind = OP_CONV;
      end
    endcase
  end

  assign s_axis_tready = (int'(count_q) < QDEPTH);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign op_valid_o    = (count_q != '0);
  assign op_o          = q_mem_q[rd_ptr_q];
  assign pop           = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= op_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/c2d_back.sv
// ----------------------------------------------------------------------------
// c2d_back
// Executes queued items: store loads, and runs the window MAC sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_back import c2d_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  c2d_geom_t        geom_i,
  input  wire logic        op_valid_i,
  input  c2d_op_t          op_i,
  output logic             op_ready_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,
  output logic [0:0]       m_axis_tuser
);

  localparam int MDEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
  localparam int KDEPTH = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic signed [ACC_W-1:0] SAT_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  logic [1:0]               state_q, state_d;
  logic [2:0]               k_q, k_d, nch_q, nch_d;
  logic [3:0]               a_q, a_d, b_q, b_d;
  logic signed [10:0]       rbase_q, rbase_d, cbase_q, cbase_d;
  logic [4:0]               row_q, col_q;
  logic                     err_q;
  logic [15:0]              bias_q;
  logic                     v1_q, in1_q, v2_q;
  logic signed [31:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     out_v_q;
  logic [4:0]               out_row_q, out_col_q;
  logic [31:0]              out_sum_q;
  logic                     out_err_q;

  logic                     pop, map_we, ker_we, issue, in_win, load_out;
  logic [8:0]               row_mul, col_mul;
  logic [9:0]               span_r, span_c, need_r, need_c;
  logic                     ok_pos;
  logic signed [10:0]       r_s, c_s;
  logic [MAW-1:0]           map_waddr, map_raddr;
  logic [KAW-1:0]           ker_waddr, ker_raddr;
  logic [15:0]              map_rdata, ker_rdata;
  logic                     b_last, a_last, k_last;
  logic [31:0]              sat_sum;

  assign op_ready_o = (state_q == S_IDLE);
  assign pop        = op_valid_i && op_ready_o;
  assign map_we     = pop && (op_i.kind == OP_SAMPLE);
  assign ker_we     = pop && (op_i.kind == OP_WEIGHT);

  assign row_mul = {4'b0, op_i.row} * {5'b0, geom_i.sr};
  assign col_mul = {4'b0, op_i.col} * {5'b0, geom_i.sc};
  assign span_r  = {1'b0, geom_i.ir} + {6'b0, geom_i.pr, 1'b0};
  assign span_c  = {1'b0, geom_i.ic} + {6'b0, geom_i.pc, 1'b0};
  assign need_r  = {1'b0, row_mul} + {6'b0, geom_i.kr};
  assign need_c  = {1'b0, col_mul} + {6'b0, geom_i.kc};
  assign ok_pos  = (span_r >= {6'b0, geom_i.kr}) && (need_r <= span_r) &&
                   (span_c >= {6'b0, geom_i.kc}) && (need_c <= span_c);
  assign rbase_d = $signed({2'b00, row_mul}) - $signed({8'b0, geom_i.pr});
  assign cbase_d = $signed({2'b00, col_mul}) - $signed({8'b0, geom_i.pc});
  assign nch_d   = (int'(op_i.used) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : op_i.used;

  assign r_s    = rbase_q + $signed({7'b0, a_q});
  assign c_s    = cbase_q + $signed({7'b0, b_q});
  assign in_win = !r_s[10] && (r_s < $signed({2'b0, geom_i.ir})) &&
                  !c_s[10] && (c_s < $signed({2'b0, geom_i.ic}));

  assign map_waddr = MAW'(int'(op_i.chan) * MAX_DIM * MAX_DIM + int'(op_i.row) * MAX_DIM +
                          int'(op_i.col));
  assign ker_waddr = KAW'(int'(op_i.chan) * MAX_KERNEL * MAX_KERNEL +
                          int'(op_i.row) * MAX_KERNEL + int'(op_i.col));
  assign map_raddr = MAW'(int'(k_q) * MAX_DIM * MAX_DIM + int'(r_s[DIM_W-1:0]) * MAX_DIM +
                          int'(c_s[DIM_W-1:0]));
  assign ker_raddr = KAW'(int'(k_q) * MAX_KERNEL * MAX_KERNEL + int'(a_q) * MAX_KERNEL +
                          int'(b_q));

  assign issue  = (state_q == S_RUN);
  assign b_last = (b_q == geom_i.kc - 4'd1);
  assign a_last = (a_q == geom_i.kr - 4'd1);
  assign k_last = (k_q == nch_q - 3'd1);

  assign load_out = (state_q == S_DONE) && (!out_v_q || m_axis_tready);
  assign sat_sum  = (acc_q > SAT_MAX) ? SAT_MAX[31:0] :
                    (acc_q < SAT_MIN) ? SAT_MIN[31:0] : acc_q[31:0];

  c2d_ram #(.WIDTH(16), .DEPTH(MDEPTH)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (op_i.value),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  c2d_ram #(.WIDTH(16), .DEPTH(KDEPTH)) u_ker_ram (
    .clk_i   (clk_i),
    .we_i    (ker_we),
    .waddr_i (ker_waddr),
    .wdata_i (op_i.value),
    .raddr_i (ker_raddr),
    .rdata_o (ker_rdata)
  );

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    a_d     = a_q;
    b_d     = b_q;
    case (state_q)
      S_IDLE: begin
        if (pop && (op_i.kind == OP_CONV)) begin
          k_d = '0;
          a_d = '0;
          b_d = '0;
          if (!ok_pos) begin
            state_d = S_DONE;
          end else if (nch_d == '0) begin
            state_d = S_DRAIN;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!b_last) begin
          b_d = b_q + 4'd1;
        end else begin
          b_d = '0;
          if (!a_last) begin
            a_d = a_q + 4'd1;
          end else begin
            a_d = '0;
            if (!k_last) begin
              k_d = k_q + 3'd1;
            end else begin
              state_d = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
      bias_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      a_q     <= a_d;
      b_q     <= b_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (pop && (op_i.kind == OP_BIAS)) begin
        bias_q <= op_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (op_i.kind == OP_CONV)) begin
      rbase_q <= rbase_d;
      cbase_q <= cbase_d;
      nch_q   <= nch_d;
      row_q   <= op_i.row;
      col_q   <= op_i.col;
      err_q   <= !ok_pos;
      acc_q   <= {{(ACC_W-24){bias_q[15]}}, bias_q, 8'b0};
    end else if (v2_q) begin
      acc_q <= acc_q + {{(ACC_W-32){prod_q[31]}}, prod_q};
    end
    if (issue) begin
      in1_q <= in_win;
    end
    if (v1_q) begin
      prod_q <= in1_q ? $signed(ker_rdata) * $signed(map_rdata) : 32'sd0;
    end
    if (load_out) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      out_err_q <= err_q;
      out_sum_q <= err_q ? '0 : sat_sum;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_err_q;

`ifndef SYNTH
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!v1_q && !v2_q))
    else $error("MAC pipeline busy while the sequencer is idle");
  a_run_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (k_q < nch_q))
    else $error("Channel counter beyond the channel count");
  a_done_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (!v1_q && !v2_q))
    else $error("Result taken before the MAC pipeline drained");
`endif

endmodule

`default_nettype wire

// File: rtl/core/conv2d_stride_pad_mac.sv
// ----------------------------------------------------------------------------
// conv2d_stride_pad_mac
// Multi-channel 2D convolution with stride and zero padding, one output
// position per compute item, computed with a single multiply-accumulate.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload (low bits first)
// s_axis    in   tdata: channel, row, col, value, channels_used; tuser: func
// m_axis    out  tdata: out_row, out_col, conv_sum; tuser: range_error
// cfg       in   cfg_index_i selects the register, cfg_data_i holds its value
//
// A load item is stored as the executing stage accepts it. A compute item
// steps through channels * ker_rows * ker_cols taps, one kernel tap per
// cycle through the single RAM read port of each store and the one
// multiplier. An out-of-range position skips the taps and sets range_error.
// A two-entry queue decouples intake from execution. A result held on
// m_axis stalls the executing stage, and the queue then fills and drops
// s_axis_tready. Reset is asynchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_stride_pad_mac import c2d_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int MAX_KERNEL   = MAX_KERNEL_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // channel, row, col, value, channels_used
  input  wire logic [1:0]  s_axis_tuser,  // func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // out_row, out_col, conv_sum
  output logic [0:0]       m_axis_tuser,  // range_error
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i
);

  localparam logic [2:0] REG_IN_ROWS  = 3'd0;
  localparam logic [2:0] REG_IN_COLS  = 3'd1;
  localparam logic [2:0] REG_KER_ROWS = 3'd2;
  localparam logic [2:0] REG_KER_COLS = 3'd3;
  localparam logic [2:0] REG_STR_ROWS = 3'd4;
  localparam logic [2:0] REG_STR_COLS = 3'd5;
  localparam logic [2:0] REG_PAD_ROWS = 3'd6;
  localparam logic [2:0] REG_PAD_COLS = 3'd7;

  logic [5:0] in_rows_q, in_cols_q;
  logic [3:0] ker_rows_q, ker_cols_q, str_rows_q, str_cols_q;
  logic [2:0] pad_rows_q, pad_cols_q;
  c2d_geom_t  geom;
  logic       op_valid, op_ready;
  c2d_op_t    op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q  <= 6'd32;
      in_cols_q  <= 6'd32;
      ker_rows_q <= 4'd3;
      ker_cols_q <= 4'd3;
      str_rows_q <= 4'd1;
      str_cols_q <= 4'd1;
      pad_rows_q <= 3'd0;
      pad_cols_q <= 3'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IN_ROWS:  in_rows_q  <= cfg_data_i;
        REG_IN_COLS:  in_cols_q  <= cfg_data_i;
        REG_KER_ROWS: ker_rows_q <= cfg_data_i[3:0];
        REG_KER_COLS: ker_cols_q <= cfg_data_i[3:0];
        REG_STR_ROWS: str_rows_q <= cfg_data_i[3:0];
        REG_STR_COLS: str_cols_q <= cfg_data_i[3:0];
        REG_PAD_ROWS: pad_rows_q <= cfg_data_i[2:0];
        REG_PAD_COLS: pad_cols_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    geom.ir = (in_rows_q == '0) ? DIM_W'(1) :
              (int'(in_rows_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(in_rows_q);
    geom.ic = (in_cols_q == '0) ? DIM_W'(1) :
              (int'(in_cols_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(in_cols_q);
    geom.kr = (ker_rows_q == '0) ? 4'd1 :
              (int'(ker_rows_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : ker_rows_q;
    geom.kc = (ker_cols_q == '0) ? 4'd1 :
              (int'(ker_cols_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : ker_cols_q;
    geom.sr = (str_rows_q == '0) ? 4'd1 : str_rows_q;
    geom.sc = (str_cols_q == '0) ? 4'd1 : str_cols_q;
    geom.pr = pad_rows_q;
    geom.pc = pad_cols_q;
  end

  c2d_front #(
    .MAX_DIM      (MAX_DIM),
    .MAX_KERNEL   (MAX_KERNEL),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .op_valid_o    (op_valid),
    .op_o          (op),
    .op_ready_i    (op_ready)
  );

  c2d_back #(
    .MAX_DIM      (MAX_DIM),
    .MAX_KERNEL   (MAX_KERNEL),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .op_valid_i    (op_valid),
    .op_i          (op),
    .op_ready_o    (op_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire
